// File: sv/acmn_pkg.sv
// ============================================================================
// acmn_pkg
// Shared constants, controller/datapath command and status types for the
// ADC capture mean and noise block.
// ============================================================================
package acmn_pkg;

    localparam int MAX_COUNT_DEF   = 16384;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 24;
    localparam int NOISE_W  = 23;
    localparam int COUNT_W  = 15;
    localparam int OUT_W    = 64;

    localparam logic [COUNT_W-1:0] TARGET_RESET = 15'd250;

    localparam int MEAN_FRAC_BITS = 8;
    localparam int VAR_FRAC_BITS  = 16;

    typedef enum logic [1:0] {
        MUL_NSQ = 2'd0,
        MUL_SS  = 2'd1,
        MUL_NN  = 2'd2
    } mul_sel_t;

    typedef enum logic {
        DIV_VAR  = 1'b0,
        DIV_MEAN = 1'b1
    } div_sel_t;

    typedef struct packed {
        logic     accept;
        logic     mul_load;
        logic     mul_step;
        mul_sel_t mul_sel;
        logic     div_load;
        logic     div_step;
        div_sel_t div_sel;
        logic     sqrt_load;
        logic     sqrt_step;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic out_free;
    } status_t;

endpackage

// File: sv/adc_capture_mean_and_noise_core.sv
// ============================================================================
// adc_capture_mean_and_noise_core
// Capture mean and noise of an ADC sample stream.
// ============================================================================
// Input stream s_*: s_tuser = 0 is a capture start, 1 is an ADC sample in
// s_tdata; s_tlast marks the last sample of a DMA block. After a start the
// first block is dropped, then samples accumulate until the target count.
// Output stream m_*: one transaction per capture with mean, noise and count.
// Configuration: cfg_we writes cfg_wdata into the target count register.
// Throughput: one input transaction per cycle while accumulating. The sample
// that completes a capture starts the compute phase, during which s_tready
// is low. The shift-add multiplier, restoring divider and square root each
// retire one bit per cycle. Once the final divide is done and the output
// register is free, the result is loaded into it and m_tvalid rises.
// Stall: a held result stays in the output register; new samples are taken
// while it waits, and only a later completed capture waits for it to leave.
// Reset: accumulators clear, the first block is armed for skipping and the
// target count returns to 250.
// ============================================================================
module adc_capture_mean_and_noise_core #(
    parameter int MAX_COUNT   = acmn_pkg::MAX_COUNT_DEF,
    parameter int SAMPLE_BITS = acmn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [acmn_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample
    input  logic                          s_tuser,   // [0] mode
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [acmn_pkg::OUT_W-1:0]    m_tdata,   // [23:0] mean_q8, [46:24] noise_q8,
                                                     // [61:47] sample_count, [63:62] zero
    input  logic                          cfg_we,
    input  logic [acmn_pkg::COUNT_W-1:0]  cfg_wdata
);
    import acmn_pkg::*;

    cmd_t    cmd;
    status_t status;

    acmn_ctrl #(
        .MAX_COUNT   (MAX_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    acmn_dp #(
        .MAX_COUNT   (MAX_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_mode   (s_tuser),
        .in_sample (s_tdata),
        .in_last   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register loaded while a result is pending");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("output valid rose without a result load");

    a_busy_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && status.hit) |=> !s_tready)
        else $error("input still ready after a capture completed");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.mul_load, cmd.mul_step, cmd.div_load,
                  cmd.div_step, cmd.sqrt_load, cmd.sqrt_step, cmd.out_load}))
        else $error("more than one datapath command in a cycle");

endmodule

// File: sv/acmn_ctrl.sv
// ============================================================================
// acmn_ctrl
// Sequencer: accepts input transactions while accumulating, then steps the
// shared multiply and divide units and the square root unit through the final compute.
// ============================================================================
module acmn_ctrl #(
    parameter int MAX_COUNT   = acmn_pkg::MAX_COUNT_DEF,
    parameter int SAMPLE_BITS = acmn_pkg::SAMPLE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  acmn_pkg::status_t status,
    output acmn_pkg::cmd_t    cmd
);
    import acmn_pkg::*;

    localparam int CW   = $clog2(MAX_COUNT + 1);
    localparam int SUMW = SAMPLE_BITS + CW;
    localparam int DVW  = 2 * SUMW + VAR_FRAC_BITS;
    localparam int RW   = DVW / 2;
    localparam int CNTW = $clog2(DVW + 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_MUL_NSQ  = 8'b0000_0010,
        S_MUL_SS   = 8'b0000_0100,
        S_MUL_NN   = 8'b0000_1000,
        S_DIV_VAR  = 8'b0001_0000,
        S_SQRT     = 8'b0010_0000,
        S_DIV_MEAN = 8'b0100_0000,
        S_OUT      = 8'b1000_0000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNTW-1:0]   cnt_reg;
    logic [CNTW-1:0]   cnt_next;
    logic              cnt_zero;
    logic              mul_last;
    logic              div_last;
    logic              sqrt_last;

    assign cnt_zero  = (cnt_reg == '0);
    assign mul_last  = (cnt_reg == CNTW'(SUMW));
    assign div_last  = (cnt_reg == CNTW'(DVW));
    assign sqrt_last = (cnt_reg == CNTW'(RW));
    assign s_tready  = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = CNTW'(cnt_reg + 1'b1);
        case (state_reg)
            S_IDLE:
            begin
                cnt_next   = '0;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.hit)
                begin
                    state_next = S_MUL_NSQ;
                end
            end
            S_MUL_NSQ:
            begin
                cmd.mul_sel  = MUL_NSQ;
                cmd.mul_load = cnt_zero;
                cmd.mul_step = !cnt_zero;
                if (mul_last)
                begin
                    state_next = S_MUL_SS;
                    cnt_next   = '0;
                end
            end
            S_MUL_SS:
            begin
                cmd.mul_sel  = MUL_SS;
                cmd.mul_load = cnt_zero;
                cmd.mul_step = !cnt_zero;
                if (mul_last)
                begin
                    state_next = S_MUL_NN;
                    cnt_next   = '0;
                end
            end
            S_MUL_NN:
            begin
                cmd.mul_sel  = MUL_NN;
                cmd.mul_load = cnt_zero;
                cmd.mul_step = !cnt_zero;
                if (mul_last)
                begin
                    state_next = S_DIV_VAR;
                    cnt_next   = '0;
                end
            end
            S_DIV_VAR:
            begin
                cmd.div_sel  = DIV_VAR;
                cmd.div_load = cnt_zero;
                cmd.div_step = !cnt_zero;
                if (div_last)
                begin
                    state_next = S_SQRT;
                    cnt_next   = '0;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_load = cnt_zero;
                cmd.sqrt_step = !cnt_zero;
                if (sqrt_last)
                begin
                    state_next = S_DIV_MEAN;
                    cnt_next   = '0;
                end
            end
            S_DIV_MEAN:
            begin
                cmd.div_sel  = DIV_MEAN;
                cmd.div_load = cnt_zero;
                cmd.div_step = !cnt_zero;
                if (div_last)
                begin
                    state_next = S_OUT;
                    cnt_next   = '0;
                end
            end
            S_OUT:
            begin
                cnt_next = '0;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: sv/acmn_dp.sv
// ============================================================================
// acmn_dp
// Datapath: target register, accumulators, shift-add multiplier, restoring
// divider, digit-recurrence square root and the output register.
// ============================================================================
module acmn_dp #(
    parameter int MAX_COUNT   = acmn_pkg::MAX_COUNT_DEF,
    parameter int SAMPLE_BITS = acmn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  acmn_pkg::cmd_t                cmd,
    output acmn_pkg::status_t             status,
    input  logic                          in_mode,
    input  logic [acmn_pkg::SAMPLE_W-1:0] in_sample,
    input  logic                          in_last,
    input  logic                          cfg_we,
    input  logic [acmn_pkg::COUNT_W-1:0]  cfg_wdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [acmn_pkg::OUT_W-1:0]    m_tdata
);
    import acmn_pkg::*;

    localparam int CW   = $clog2(MAX_COUNT + 1);
    localparam int GW   = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int SUMW = SAMPLE_BITS + CW;
    localparam int SQW  = 2 * SAMPLE_BITS + CW;
    localparam int PW   = 2 * SUMW;
    localparam int DVW  = PW + VAR_FRAC_BITS;
    localparam int DNW  = 2 * CW;
    localparam int RW   = DVW / 2;
    localparam int RMW  = RW + 2;
    localparam int PADW = OUT_W - MEAN_W - NOISE_W - COUNT_W;

    // configuration and accumulators
    logic [COUNT_W-1:0]       target_reg;
    logic [SUMW-1:0]          sum_reg;
    logic [SQW-1:0]           sq_reg;
    logic [CW-1:0]            count_reg;
    logic                     skip_reg;
    logic                     done_reg;

    logic [SAMPLE_BITS-1:0]   s;
    logic [2*SAMPLE_BITS-1:0] s_sq;
    logic [CW-1:0]            count_inc;
    logic [GW-1:0]            tgt_ext;
    logic [GW-1:0]            goal;

    // multiplier
    logic [PW-1:0]            ma_reg;
    logic [SUMW-1:0]          mb_reg;
    logic [PW-1:0]            acc_reg;
    logic [PW-1:0]            p1_reg;
    logic [PW-1:0]            var_reg;

    // divider
    logic [DVW-1:0]           dq_reg;
    logic [DNW-1:0]           dr_reg;
    logic [DNW-1:0]           dd_reg;
    logic [DNW:0]             div_sh;
    logic                     div_ge;

    // square root
    logic [DVW-1:0]           sx_reg;
    logic [RMW-1:0]           sr_reg;
    logic [RW-1:0]            rt_reg;
    logic [RMW+1:0]           sq_sh;
    logic [RMW+1:0]           sq_trial;
    logic                     sq_ge;
    logic [NOISE_W-1:0]       noise_reg;

    // output register
    logic                     m_valid_reg;
    logic [MEAN_W-1:0]        o_mean_reg;
    logic [NOISE_W-1:0]       o_noise_reg;
    logic [COUNT_W-1:0]       o_count_reg;

    assign s         = in_sample[SAMPLE_BITS-1:0];
    assign s_sq      = s * s;
    assign count_inc = CW'(count_reg + 1'b1);
    assign tgt_ext   = GW'(target_reg);

    always_comb
    begin
        if (tgt_ext == '0)
        begin
            goal = GW'(1);
        end
        else if (tgt_ext > GW'(MAX_COUNT))
        begin
            goal = GW'(MAX_COUNT);
        end
        else
        begin
            goal = tgt_ext;
        end
    end

    assign status.hit      = in_mode && !done_reg && !skip_reg && (GW'(count_inc) >= goal);
    assign status.out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
        end
        else if (cfg_we)
        begin
            target_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            sq_reg    <= '0;
            count_reg <= '0;
            skip_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (!in_mode)
            begin
                sum_reg   <= '0;
                sq_reg    <= '0;
                count_reg <= '0;
                skip_reg  <= 1'b1;
                done_reg  <= 1'b0;
            end
            else if (!done_reg)
            begin
                if (skip_reg)
                begin
                    if (in_last)
                    begin
                        skip_reg <= 1'b0;
                    end
                end
                else
                begin
                    sum_reg   <= SUMW'(sum_reg + SUMW'(s));
                    sq_reg    <= SQW'(sq_reg + SQW'(s_sq));
                    count_reg <= count_inc;
                    if (status.hit)
                    begin
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            acc_reg <= '0;
            case (cmd.mul_sel)
                MUL_NSQ:
                begin
                    ma_reg <= PW'(sq_reg);
                    mb_reg <= SUMW'(count_reg);
                end
                MUL_SS:
                begin
                    ma_reg <= PW'(sum_reg);
                    mb_reg <= sum_reg;
                    p1_reg <= acc_reg;
                end
                MUL_NN:
                begin
                    ma_reg  <= PW'(count_reg);
                    mb_reg  <= SUMW'(count_reg);
                    var_reg <= PW'(p1_reg - acc_reg);
                end
                default:
                begin
                    ma_reg <= '0;
                    mb_reg <= '0;
                end
            endcase
        end
        else if (cmd.mul_step)
        begin
            if (mb_reg[0])
            begin
                acc_reg <= PW'(acc_reg + ma_reg);
            end
            ma_reg <= {ma_reg[PW-2:0], 1'b0};
            mb_reg <= {1'b0, mb_reg[SUMW-1:1]};
        end
    end

    assign div_sh = {dr_reg, dq_reg[DVW-1]};
    assign div_ge = (div_sh >= {1'b0, dd_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dr_reg <= '0;
            case (cmd.div_sel)
                DIV_VAR:
                begin
                    dq_reg <= {var_reg, {VAR_FRAC_BITS{1'b0}}};
                    dd_reg <= acc_reg[DNW-1:0];
                end
                DIV_MEAN:
                begin
                    dq_reg    <= DVW'({sum_reg, {MEAN_FRAC_BITS{1'b0}}});
                    dd_reg    <= DNW'(count_reg);
                    noise_reg <= NOISE_W'(rt_reg);
                end
                default:
                begin
                    dq_reg <= '0;
                    dd_reg <= '0;
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                dr_reg <= DNW'(div_sh - {1'b0, dd_reg});
                dq_reg <= {dq_reg[DVW-2:0], 1'b1};
            end
            else
            begin
                dr_reg <= div_sh[DNW-1:0];
                dq_reg <= {dq_reg[DVW-2:0], 1'b0};
            end
        end
    end

    assign sq_sh    = {sr_reg, sx_reg[DVW-1:DVW-2]};
    assign sq_trial = (RMW+2)'({rt_reg, 2'b01});
    assign sq_ge    = (sq_sh >= sq_trial);

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            sx_reg <= dq_reg;
            sr_reg <= '0;
            rt_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sx_reg <= {sx_reg[DVW-3:0], 2'b00};
            if (sq_ge)
            begin
                sr_reg <= RMW'(sq_sh - sq_trial);
                rt_reg <= {rt_reg[RW-2:0], 1'b1};
            end
            else
            begin
                sr_reg <= sq_sh[RMW-1:0];
                rt_reg <= {rt_reg[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_mean_reg  <= MEAN_W'(dq_reg);
            o_noise_reg <= noise_reg;
            o_count_reg <= COUNT_W'(count_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PADW{1'b0}}, o_count_reg, o_noise_reg, o_mean_reg};

endmodule
